[sv/sfe_pkg.sv]
// ----------------------------------------------------------------------------
// SBUS frame encoder package
// Shared widths, opcodes and frame constants for the SBUS frame encoder.
// ----------------------------------------------------------------------------
package sfe_pkg;

    localparam int MAX_BUSES_DEF = 2;
    localparam int CHANNELS      = 16;
    localparam int CH_BITS       = 11;
    localparam int FRAME_LEN     = 25;
    localparam int PACKED_LAST   = 22;
    localparam int FLAGS_POS     = 23;

    localparam logic [7:0]         START_BYTE = 8'h0F;
    localparam logic [7:0]         FLAGS_BYTE = 8'h00;
    localparam logic [7:0]         END_BYTE   = 8'h00;
    localparam logic [CH_BITS-1:0] VALUE_MAX  = 11'h7FF;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SEND  = 1'b1;

    typedef logic [7:0]         t_byte;
    typedef logic [CH_BITS-1:0] t_chval;

endpackage

[sv/sfe_if.sv]
// ----------------------------------------------------------------------------
// SBUS frame encoder channels
// Input command channel and output frame byte channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sfe_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic        bus_number;
    logic [3:0]  channel_number;
    logic [15:0] channel_value;

    modport source (output valid, opcode, bus_number, channel_number, channel_value,
                    input ready);
    modport sink   (input valid, opcode, bus_number, channel_number, channel_value,
                    output ready);
endinterface

interface sfe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_bus;
    logic [4:0] byte_position;
    logic       last_byte;

    modport source (output valid, frame_byte, frame_bus, byte_position, last_byte,
                    input ready);
    modport sink   (input valid, frame_byte, frame_bus, byte_position, last_byte,
                    output ready);
endinterface

[sv/sbus_frame_encoder.sv]
// ----------------------------------------------------------------------------
// SBUS frame encoder
// A write command stores a saturated 11-bit channel value.
// A send command streams one 25-byte frame per active bus, one byte per cycle
// while the output side takes every byte. A send holds off further commands
// until the last byte of its last frame has entered the output register;
// output stalls lengthen this. The bit accumulator assembles one packed byte
// per cycle from the channel store, again while the output is not stalled.
// The store is cleared at reset through per-entry valid bits, so there is no
// clearing pass. Bytes leave through an output register, so the last byte of a
// send may still wait while the next command is accepted.
// ----------------------------------------------------------------------------
module sbus_frame_encoder
    import sfe_pkg::*;
#(
    parameter int MAX_BUSES = MAX_BUSES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_wdata,
    sfe_in_if.sink          i_in,
    sfe_out_if.source       o_out
);

    localparam int DEPTH = MAX_BUSES * CHANNELS;
    localparam int AW    = $clog2(DEPTH);

    // Channel store with valid bits.
    t_chval             mem [DEPTH];
    logic [DEPTH-1:0]   r_vld;
    t_chval             r_rd_raw;
    logic               r_rd_vld;

    logic [1:0]  r_active;
    logic        r_busy,  n_busy;
    logic        r_bus,   n_bus;
    logic [1:0]  r_nbus,  n_nbus;
    logic [4:0]  r_pos,   n_pos;
    logic [3:0]  r_ch,    n_ch;
    logic [17:0] r_acc,   n_acc;
    logic [4:0]  r_nbits, n_nbits;

    logic        r_out_valid, n_out_valid;
    t_byte       r_out_byte,  n_out_byte;
    logic        r_out_bus,   n_out_bus;
    logic [4:0]  r_out_pos,   n_out_pos;
    logic        r_out_last,  n_out_last;

    logic        w_in_xfer;
    logic        w_step;
    logic        w_load;
    logic [17:0] w_merged;
    logic [4:0]  w_nb;
    t_chval      w_ch_data;
    t_chval      w_wr_val;
    logic [1:0]  w_eff;
    logic        w_last;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_wr_addr;
    logic        w_wr_en;

    assign i_in.ready = !r_busy;
    assign w_in_xfer  = i_in.valid && !r_busy;
    assign w_step     = r_busy && (!r_out_valid || o_out.ready);

    assign w_wr_val  = (|i_in.channel_value[15:CH_BITS]) ? VALUE_MAX
                                                         : i_in.channel_value[CH_BITS-1:0];
    assign w_wr_addr = AW'({i_in.bus_number, i_in.channel_number});
    assign w_wr_en   = w_in_xfer && (i_in.opcode == OP_WRITE)
                       && (32'(i_in.bus_number) < MAX_BUSES);

    assign w_eff = (32'(r_active) > MAX_BUSES) ? 2'(MAX_BUSES) : r_active;

    assign w_ch_data = r_rd_vld ? r_rd_raw : '0;
    assign w_load    = (r_nbits < 5'd8);
    assign w_merged  = w_load ? (r_acc | (18'(w_ch_data) << r_nbits)) : r_acc;
    assign w_nb      = w_load ? (r_nbits + 5'(CH_BITS)) : r_nbits;
    assign w_last    = (r_pos == 5'(FRAME_LEN - 1)) && ((2'(r_bus) + 2'd1) == r_nbus);

    always_comb begin
        n_busy      = r_busy;
        n_bus       = r_bus;
        n_nbus      = r_nbus;
        n_pos       = r_pos;
        n_ch        = r_ch;
        n_acc       = r_acc;
        n_nbits     = r_nbits;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_byte  = r_out_byte;
        n_out_bus   = r_out_bus;
        n_out_pos   = r_out_pos;
        n_out_last  = r_out_last;

        if (w_in_xfer && (i_in.opcode == OP_SEND) && (w_eff != 2'd0)) begin
            n_busy  = 1'b1;
            n_bus   = 1'b0;
            n_nbus  = w_eff;
            n_pos   = '0;
            n_ch    = '0;
            n_acc   = '0;
            n_nbits = '0;
        end

        if (w_step) begin
            n_out_valid = 1'b1;
            n_out_bus   = r_bus;
            n_out_pos   = r_pos;
            n_out_last  = w_last;
            case (r_pos) inside
                5'd0: begin
                    n_out_byte = START_BYTE;
                    n_acc      = '0;
                    n_nbits    = '0;
                    n_ch       = '0;
                end
                [5'd1:5'(PACKED_LAST)]: begin
                    n_out_byte = w_merged[7:0];
                    n_acc      = w_merged >> 8;
                    n_nbits    = w_nb - 5'd8;
                    if (w_load) begin
                        n_ch = r_ch + 4'd1;
                    end
                end
                5'(FLAGS_POS): begin
                    n_out_byte = FLAGS_BYTE;
                end
                default: begin
                    n_out_byte = END_BYTE;
                end
            endcase

            if (r_pos == 5'(FRAME_LEN - 1)) begin
                n_pos = '0;
                if (w_last) begin
                    n_busy = 1'b0;
                end else begin
                    n_bus = r_bus + 1'b1;
                end
            end else begin
                n_pos = r_pos + 5'd1;
            end
        end
    end

    // The read port follows the next channel pointer, so the registered data
    // always holds the entry the accumulator will take next.
    assign w_rd_addr = AW'({n_bus, n_ch});

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_val;
        end
        r_rd_raw <= mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_rd_vld    <= 1'b0;
            r_active    <= 2'd1;
            r_busy      <= 1'b0;
            r_bus       <= 1'b0;
            r_nbus      <= '0;
            r_pos       <= '0;
            r_ch        <= '0;
            r_acc       <= '0;
            r_nbits     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr_en) begin
                r_vld[w_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[w_rd_addr];
            if (i_cfg_we) begin
                r_active <= i_cfg_wdata;
            end
            r_busy      <= n_busy;
            r_bus       <= n_bus;
            r_nbus      <= n_nbus;
            r_pos       <= n_pos;
            r_ch        <= n_ch;
            r_acc       <= n_acc;
            r_nbits     <= n_nbits;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_byte <= n_out_byte;
        r_out_bus  <= n_out_bus;
        r_out_pos  <= n_out_pos;
        r_out_last <= n_out_last;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.frame_byte    = r_out_byte;
    assign o_out.frame_bus     = r_out_bus;
    assign o_out.byte_position = r_out_pos;
    assign o_out.last_byte     = r_out_last;

`ifndef SYNTHESIS
    // All 176 packed bits are consumed by the time the flags byte is due.
    a_packing_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_pos == 5'(FLAGS_POS))) |-> (r_nbits == 5'd0))
        else $error("bit accumulator not empty at flags byte");

    // The final flag only ever marks the end byte of a frame.
    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_out_pos == 5'(FRAME_LEN - 1)))
        else $error("last byte flag away from frame end");

    // Every frame opens with the start byte.
    a_start_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_pos == 5'd0)) |-> (r_out_byte == START_BYTE))
        else $error("frame does not open with start byte");

    // Channel 0 is fetched only for the first packed byte, so the pointer
    // wraps only after the last channel of a frame has been taken.
    a_channel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_load && (r_pos != 5'd0) && (r_pos <= 5'(PACKED_LAST))
            && (r_ch == 4'd0)) |-> (r_pos == 5'd1))
        else $error("channel pointer wrapped inside a frame");
`endif

endmodule
